FILE: rtl/core/bps_pkg.sv
// Shared constants and types for the byte pattern search block.
`default_nettype none
package bps_pkg;
   localparam int PATTERN_MAX   = 256;
   localparam int BLOCK_BYTES   = 4096;
   localparam int PAT_IDX_W     = $clog2(PATTERN_MAX);
   localparam int INDEX_W       = 8;
   localparam int BYTE_W        = 8;
   localparam int LEN_W         = 9;
   localparam int OFFSET_W      = 12;
   localparam logic [OFFSET_W-1:0] LAST_OFFSET = OFFSET_W'(BLOCK_BYTES - 1);
   localparam logic [LEN_W-1:0]    LEN_LIMIT   = LEN_W'(PATTERN_MAX);

   typedef enum logic {
      ACT_LOAD = 1'b0,
      ACT_DATA = 1'b1
   } action_type;
endpackage
`default_nettype wire

FILE: rtl/core/bps_if.sv
// Channel interfaces for requests, results and the length register.
`default_nettype none
interface bps_req_if import bps_pkg::*; ;
   logic                valid;
   logic                ready;
   logic                action;
   logic [INDEX_W-1:0]  pattern_index;
   logic [BYTE_W-1:0]   byte_value;
   logic                last_in_block;
   modport source (output valid, action, pattern_index, byte_value, last_in_block,
                   input ready);
   modport sink   (input valid, action, pattern_index, byte_value, last_in_block,
                   output ready);
endinterface

interface bps_rsp_if import bps_pkg::*; ;
   logic                valid;
   logic                ready;
   logic                found;
   logic [OFFSET_W-1:0] match_offset;
   modport source (output valid, found, match_offset, input ready);
   modport sink   (input valid, found, match_offset, output ready);
endinterface

interface bps_csr_if import bps_pkg::*; ;
   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/bps_cell.sv
// One cell of the match chain: a pattern byte and its partial match bit.
`default_nettype none
module bps_cell import bps_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              shift_en,
   input  wire logic              write_en,
   input  wire logic [BYTE_W-1:0] write_byte,
   input  wire logic [BYTE_W-1:0] data_byte,
   input  wire logic              match_prev,
   output logic                   match_out
);
   logic [BYTE_W-1:0] pat_ff;
   logic              pm_ff;
   logic              pm_in;

   always_comb begin
      pm_in = match_prev && (pat_ff == data_byte);
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         pat_ff <= write_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pm_ff <= 1'b0;
      end else if (shift_en) begin
         pm_ff <= pm_in;
      end
   end

   assign match_out = pm_ff;
endmodule
`default_nettype wire

FILE: rtl/core/bps_chain.sv
// Row of match cells; each cell extends the candidate held by its neighbor.
`default_nettype none
module bps_chain import bps_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 shift_en,
   input  wire logic                 block_start,
   input  wire logic                 load_en,
   input  wire logic [INDEX_W-1:0]   load_index,
   input  wire logic [BYTE_W-1:0]    byte_value,
   output logic [PATTERN_MAX-1:0]    match_vec
);
   logic [PATTERN_MAX-1:0] prev_vec;

   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      logic wr_en;
      assign wr_en = load_en
                     && ({{(32-INDEX_W){1'b0}}, load_index} == 32'(k));
      if (k == 0) begin : g_head
         assign prev_vec[k] = 1'b1;
      end else begin : g_body
         // drop candidates left over from the previous block
         assign prev_vec[k] = match_vec[k-1] && !block_start;
      end
      bps_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (shift_en),
         .write_en   (wr_en),
         .write_byte (byte_value),
         .data_byte  (byte_value),
         .match_prev (prev_vec[k]),
         .match_out  (match_vec[k])
      );
   end
endmodule
`default_nettype wire

FILE: rtl/core/byte_pattern_search.sv
// Top level of the streaming byte pattern search.
// Usage:
//   req: one word per cycle while ready is high. action 0 loads
//        byte_value into pattern slot pattern_index; action 1 searches
//        byte_value as the next data byte, and last_in_block ends the
//        block (a block also ends on its 4096th data byte).
//   rsp: one word per block: found and the start offset of the first match
//        lying wholly inside the block (0 when not found).
//   csr: writes pattern_length; always ready, write only while idle.
// Throughput: one word per cycle while req.ready is high. Every data byte
//   shifts a 256-cell chain of partial matches.
// Result path: accepting the block's final byte loads the chain and the
//   evaluation stage; the match evaluation then lands in the output
//   register unless an earlier result still waits there untaken.
// Reset: clears the chain, byte counter, match tracking and output valid;
//   pattern_length returns to 1; pattern bytes stay undefined until loaded.
// Stall: one finished result waits in the output register while input keeps
//   flowing; req.ready drops only when a second block end reaches the
//   evaluation stage before the waiting result is taken.
`default_nettype none
module byte_pattern_search import bps_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   bps_req_if.sink   req,
   bps_rsp_if.source rsp,
   bps_csr_if.sink   csr
);
   logic [LEN_W-1:0]       len_ff;
   logic [OFFSET_W-1:0]    offset_ff;
   logic [OFFSET_W-1:0]    offset_in;
   logic                   fresh_ff;
   logic                   s1_valid_ff;
   logic                   s1_done_ff;
   logic [OFFSET_W-1:0]    s1_offset_ff;
   logic                   seen_ff;
   logic [OFFSET_W-1:0]    start_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_found_ff;
   logic [OFFSET_W-1:0]    rsp_offset_ff;

   logic                   stall;
   logic                   accept;
   logic                   take_data;
   logic                   take_load;
   logic                   done;
   logic                   s1_fire;
   logic [PATTERN_MAX-1:0] match_vec;
   logic [LEN_W-1:0]       len_eff;
   logic [LEN_W-1:0]       len_m1;
   logic                   hit;
   logic [OFFSET_W-1:0]    cand;
   logic                   seen_in;
   logic [OFFSET_W-1:0]    start_in;

   assign stall     = s1_valid_ff && s1_done_ff && rsp_valid_ff && !rsp.ready;
   assign req.ready = !stall;
   assign accept    = req.valid && req.ready;
   assign take_data = accept && (action_type'(req.action) == ACT_DATA);
   assign take_load = accept && (action_type'(req.action) == ACT_LOAD);
   assign done      = req.last_in_block || (offset_ff >= LAST_OFFSET);
   assign s1_fire   = s1_valid_ff && !stall;
   assign csr.ready = 1'b1;

   always_comb begin
      offset_in = offset_ff + OFFSET_W'(1);
      if (done) begin
         offset_in = '0;
      end
   end

   bps_chain u_chain (
      .clock       (clock),
      .reset       (reset),
      .shift_en    (take_data),
      .block_start (fresh_ff),
      .load_en     (take_load),
      .load_index  (req.pattern_index),
      .byte_value  (req.byte_value),
      .match_vec   (match_vec)
   );

   // evaluate the match of the byte held in the evaluation stage (the byte last shifted into the chain)
   always_comb begin
      len_eff = (len_ff > LEN_LIMIT) ? LEN_LIMIT : len_ff;
      len_m1  = len_eff - LEN_W'(1);
      if (len_eff == '0) begin
         hit  = 1'b1;
         cand = s1_offset_ff;
      end else begin
         hit  = match_vec[len_m1[PAT_IDX_W-1:0]];
         cand = s1_offset_ff - OFFSET_W'(len_m1);
      end
      seen_in  = seen_ff || hit;
      start_in = seen_ff ? start_ff : (hit ? cand : start_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_W'(1);
      end else if (csr.valid && csr.ready) begin
         len_ff <= csr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         fresh_ff     <= 1'b1;
         s1_valid_ff  <= 1'b0;
         s1_done_ff   <= 1'b0;
         s1_offset_ff <= '0;
      end else begin
         if (take_data) begin
            offset_ff    <= offset_in;
            fresh_ff     <= done;
            s1_valid_ff  <= 1'b1;
            s1_done_ff   <= done;
            s1_offset_ff <= offset_ff;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= 1'b0;
         start_ff <= '0;
      end else if (s1_fire) begin
         if (s1_done_ff) begin
            seen_ff  <= 1'b0;
            start_ff <= '0;
         end else begin
            seen_ff  <= seen_in;
            start_ff <= start_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire && s1_done_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_done_ff) begin
         rsp_found_ff  <= seen_in;
         rsp_offset_ff <= seen_in ? start_in : '0;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.found        = rsp_found_ff;
   assign rsp.match_offset = rsp_offset_ff;
endmodule
`default_nettype wire
